// File: rtl/assert_macros.svh
// Assertion helpers for the lamp stretcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/tlms_pkg.sv
package tlms_pkg;

    // Field and timer widths
    localparam int TIME_BITS = 10;
    localparam int CFG_BITS  = 10;
    localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
    localparam int CH_BITS   = 16;
    localparam int CMD_BITS  = 8;
    localparam int NUM_LAMPS = 6;
    localparam int IDX_BITS  = 2;

    typedef logic [TIME_BITS-1:0] t_timer;
    typedef logic [CFG_BITS-1:0]  t_cfg;
    typedef logic [CH_BITS-1:0]   t_word;
    typedef logic [CMP_BITS-1:0]  t_cmp;

    // Largest on-time a timer can hold
    localparam t_cmp TIME_MAX_EXT = t_cmp'((64'd1 << TIME_BITS) - 64'd1);

    // Register indexes
    typedef enum logic [IDX_BITS-1:0] {
        CFG_MIN_ON    = 2'd0,
        CFG_PRESS_THR = 2'd1
    } t_cfg_idx;

    localparam t_cfg MIN_ON_RESET    = 10'd200;
    localparam t_cfg PRESS_THR_RESET = 10'd50;

    // Lamp positions in lamp_bits
    localparam int LAMP_RR = 0;
    localparam int LAMP_RL = 1;
    localparam int LAMP_PU = 2;
    localparam int LAMP_PD = 3;
    localparam int LAMP_YR = 4;
    localparam int LAMP_YL = 5;

    localparam t_word LAMP_MASK [NUM_LAMPS] = '{
        16'h0100, 16'h0080, 16'h0800, 16'h1000, 16'h0400, 16'h0200
    };

    // New state of one lamp and its on-timer
    typedef struct packed {
        logic   on;
        t_timer timer;
    } t_stretch;

endpackage

// File: rtl/thruster_lamp_min_on_stretcher_core.sv
// Minimum on-time stretcher for six jet activity lamps. One transaction on
// the input channel is one tick; it produces exactly one result transaction.
// A tick is taken every clock cycle unless the output stalls; its result passes
// through the input register, then the result register, where it is presented
// until taken. The per-tick lamp and timer update is combinational between the
// two registers, which sets that one-tick-per-clock rate. The input side
// stays ready while a finished result waits, as long as the input register is
// free. Configuration writes take effect at once and belong to idle periods;
// writes to an unknown index are dropped.
`include "assert_macros.svh"

module thruster_lamp_min_on_stretcher_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [tlms_pkg::IDX_BITS-1:0]        i_cfg_idx,
    input  logic [tlms_pkg::CFG_BITS-1:0]        i_cfg_data,
    // tick input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [tlms_pkg::CMD_BITS-1:0] i_roll_command,
    input  logic signed [tlms_pkg::CMD_BITS-1:0] i_pitch_command,
    input  logic signed [tlms_pkg::CMD_BITS-1:0] i_yaw_command,
    input  logic [9:0]                           i_dynamic_pressure,
    input  logic [9:0]                           i_elapsed_ms,
    input  logic [tlms_pkg::CH_BITS-1:0]         i_first_channel_in,
    input  logic [tlms_pkg::CH_BITS-1:0]         i_second_channel_in,
    // result output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tlms_pkg::NUM_LAMPS-1:0]       o_lamp_bits,
    output logic [tlms_pkg::CH_BITS-1:0]         o_first_channel_out,
    output logic [tlms_pkg::CH_BITS-1:0]         o_second_channel_out,
    output logic                                 o_high_pressure_mode
);

    // Configuration registers
    tlms_pkg::t_cfg r_min_on;
    tlms_pkg::t_cfg r_press_thr;

    // Input register
    logic                                 r_in_valid;
    logic signed [tlms_pkg::CMD_BITS-1:0] r_roll;
    logic signed [tlms_pkg::CMD_BITS-1:0] r_pitch;
    logic signed [tlms_pkg::CMD_BITS-1:0] r_yaw;
    logic [9:0]                           r_press;
    logic [9:0]                           r_dt;
    tlms_pkg::t_word                      r_ch1;
    tlms_pkg::t_word                      r_ch2;

    // Lamp state
    tlms_pkg::t_timer                 r_timers [tlms_pkg::NUM_LAMPS];
    logic [tlms_pkg::NUM_LAMPS-1:0]   r_lamp_flags;
    tlms_pkg::t_timer                 n_timers [tlms_pkg::NUM_LAMPS];
    logic [tlms_pkg::NUM_LAMPS-1:0]   n_lamp_flags;

    // Result register
    logic                             r_out_valid;
    logic [tlms_pkg::NUM_LAMPS-1:0]   r_out_lamps;
    tlms_pkg::t_word                  r_out_ch1;
    tlms_pkg::t_word                  r_out_ch2;
    logic                             r_out_high;
    tlms_pkg::t_word                  n_masks;

    logic advance;
    logic high;
    logic yaw_big;
    tlms_pkg::t_stretch s_rr_low;
    tlms_pkg::t_stretch s_rr_high;
    tlms_pkg::t_stretch s_rl;
    tlms_pkg::t_stretch s_pu;
    tlms_pkg::t_stretch s_pd;
    tlms_pkg::t_stretch s_yr;
    tlms_pkg::t_stretch s_yl;

    // One lamp: load on turn-on, count down while on, turn off at zero
    function automatic tlms_pkg::t_stretch stretch(
        input logic             cmd,
        input logic             was_on,
        input tlms_pkg::t_timer t,
        input tlms_pkg::t_cfg   min_on,
        input logic [9:0]       dt
    );
        tlms_pkg::t_stretch res;
        tlms_pkg::t_cmp     t_w;
        tlms_pkg::t_cmp     dt_w;
        tlms_pkg::t_cmp     m_w;
        tlms_pkg::t_cmp     dec;
        tlms_pkg::t_cmp     load;
        t_w  = tlms_pkg::t_cmp'(t);
        dt_w = tlms_pkg::t_cmp'(dt);
        m_w  = tlms_pkg::t_cmp'(min_on);
        dec  = (t_w > dt_w) ? (t_w - dt_w) : '0;
        load = (m_w > tlms_pkg::TIME_MAX_EXT) ? tlms_pkg::TIME_MAX_EXT : m_w;
        if (cmd) begin
            res.on    = 1'b1;
            res.timer = was_on ? tlms_pkg::t_timer'(dec) : tlms_pkg::t_timer'(load);
        end else if (t != '0) begin
            res.on    = 1'b1;
            res.timer = tlms_pkg::t_timer'(dec);
        end else begin
            res.on    = 1'b0;
            res.timer = t;
        end
        return res;
    endfunction

    // Handshake: move a tick into the result register when it is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Evaluate all lamp candidates for the held tick
    assign high    = (r_press >= r_press_thr);
    assign yaw_big = (r_yaw >= 8'sd3) || (r_yaw <= -8'sd3);

    assign s_rr_low  = stretch(r_roll > 8'sd0, r_lamp_flags[tlms_pkg::LAMP_RR],
                               r_timers[tlms_pkg::LAMP_RR], r_min_on, r_dt);
    assign s_rr_high = stretch(yaw_big, r_lamp_flags[tlms_pkg::LAMP_RR],
                               r_timers[tlms_pkg::LAMP_RR], r_min_on, r_dt);
    assign s_rl = stretch(r_roll < 8'sd0, r_lamp_flags[tlms_pkg::LAMP_RL],
                          r_timers[tlms_pkg::LAMP_RL], r_min_on, r_dt);
    assign s_pu = stretch(r_pitch > 8'sd0, r_lamp_flags[tlms_pkg::LAMP_PU],
                          r_timers[tlms_pkg::LAMP_PU], r_min_on, r_dt);
    assign s_pd = stretch(r_pitch < 8'sd0, r_lamp_flags[tlms_pkg::LAMP_PD],
                          r_timers[tlms_pkg::LAMP_PD], r_min_on, r_dt);
    assign s_yr = stretch(r_yaw >= 8'sd2, r_lamp_flags[tlms_pkg::LAMP_YR],
                          r_timers[tlms_pkg::LAMP_YR], r_min_on, r_dt);
    assign s_yl = stretch(r_yaw <= -8'sd2, r_lamp_flags[tlms_pkg::LAMP_YL],
                          r_timers[tlms_pkg::LAMP_YL], r_min_on, r_dt);

    // Select the next lamp state by pressure mode
    always_comb begin
        for (int i = 0; i < tlms_pkg::NUM_LAMPS; i++) begin
            n_timers[i] = r_timers[i];
        end
        n_lamp_flags = r_lamp_flags;
        if (high) begin
            n_timers[tlms_pkg::LAMP_RR]     = s_rr_high.timer;
            n_lamp_flags[tlms_pkg::LAMP_RR] = s_rr_high.on;
            n_lamp_flags[tlms_pkg::LAMP_RL] = s_rr_high.on;
            n_lamp_flags[tlms_pkg::LAMP_PU] = 1'b0;
            n_lamp_flags[tlms_pkg::LAMP_PD] = 1'b0;
        end else begin
            n_timers[tlms_pkg::LAMP_RR]     = s_rr_low.timer;
            n_lamp_flags[tlms_pkg::LAMP_RR] = s_rr_low.on;
            n_timers[tlms_pkg::LAMP_RL]     = s_rl.timer;
            n_lamp_flags[tlms_pkg::LAMP_RL] = s_rl.on;
            n_timers[tlms_pkg::LAMP_PU]     = s_pu.timer;
            n_lamp_flags[tlms_pkg::LAMP_PU] = s_pu.on;
            n_timers[tlms_pkg::LAMP_PD]     = s_pd.timer;
            n_lamp_flags[tlms_pkg::LAMP_PD] = s_pd.on;
        end
        n_timers[tlms_pkg::LAMP_YR]     = s_yr.timer;
        n_lamp_flags[tlms_pkg::LAMP_YR] = s_yr.on;
        n_timers[tlms_pkg::LAMP_YL]     = s_yl.timer;
        n_lamp_flags[tlms_pkg::LAMP_YL] = s_yl.on;
    end

    // Gather the channel masks of the lamps that are on
    always_comb begin
        n_masks = '0;
        for (int i = 0; i < tlms_pkg::NUM_LAMPS; i++) begin
            if (n_lamp_flags[i]) begin
                n_masks = n_masks | tlms_pkg::LAMP_MASK[i];
            end
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_on    <= tlms_pkg::MIN_ON_RESET;
            r_press_thr <= tlms_pkg::PRESS_THR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tlms_pkg::CFG_MIN_ON) begin
                r_min_on <= i_cfg_data;
            end else if (i_cfg_idx == tlms_pkg::CFG_PRESS_THR) begin
                r_press_thr <= i_cfg_data;
            end
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_roll  <= i_roll_command;
            r_pitch <= i_pitch_command;
            r_yaw   <= i_yaw_command;
            r_press <= i_dynamic_pressure;
            r_dt    <= i_elapsed_ms;
            r_ch1   <= i_first_channel_in;
            r_ch2   <= i_second_channel_in;
        end
    end

    // Advance lamp state with each tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tlms_pkg::NUM_LAMPS; i++) begin
                r_timers[i] <= '0;
            end
            r_lamp_flags <= '0;
        end else if (advance) begin
            for (int i = 0; i < tlms_pkg::NUM_LAMPS; i++) begin
                r_timers[i] <= n_timers[i];
            end
            r_lamp_flags <= n_lamp_flags;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_lamps <= n_lamp_flags;
            r_out_ch1   <= r_ch1 | n_masks;
            r_out_ch2   <= r_ch2 | n_masks;
            r_out_high  <= high;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_lamp_bits          = r_out_lamps;
    assign o_first_channel_out  = r_out_ch1;
    assign o_second_channel_out = r_out_ch2;
    assign o_high_pressure_mode = r_out_high;

    // Lamp state always matches the most recent result
    `ASSERT_IMPL(a_flags_match_out, i_clk, i_rst_n, r_out_valid,
        r_lamp_flags == r_out_lamps)
    // Empty result register never blocks the input side
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, o_in_ready)
    // High pressure: pitch lamps dark, both roll lamps agree
    `ASSERT_IMPL(a_high_mode_lamps, i_clk, i_rst_n, r_out_valid && r_out_high,
        (r_out_lamps[tlms_pkg::LAMP_PU] == 1'b0) &&
        (r_out_lamps[tlms_pkg::LAMP_PD] == 1'b0) &&
        (r_out_lamps[tlms_pkg::LAMP_RR] == r_out_lamps[tlms_pkg::LAMP_RL]))
    // A lit roll-right lamp shows in both channel words
    `ASSERT_IMPL(a_rr_mask, i_clk, i_rst_n, r_out_valid && r_out_lamps[tlms_pkg::LAMP_RR],
        r_out_ch1[8] && r_out_ch2[8])

endmodule

// File: tb/thruster_lamp_min_on_stretcher_core_tb.sv
module thruster_lamp_min_on_stretcher_core_tb;

    // Register indexes the block does not decode
    localparam logic [tlms_pkg::IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [tlms_pkg::IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 116;
    localparam int HOLD_CYCLES  = 80;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic signed [tlms_pkg::CMD_BITS-1:0] roll;
        logic signed [tlms_pkg::CMD_BITS-1:0] pitch;
        logic signed [tlms_pkg::CMD_BITS-1:0] yaw;
        logic [9:0]                           press;
        logic [9:0]                           dt;
        tlms_pkg::t_word                      ch1;
        tlms_pkg::t_word                      ch2;
    } t_tick;

    typedef struct packed {
        logic [tlms_pkg::NUM_LAMPS-1:0] lamps;
        tlms_pkg::t_word                ch1;
        tlms_pkg::t_word                ch2;
        logic                           hp;
    } t_lamp_word;

    typedef struct packed {
        t_tick      tk;
        logic       typed;
        t_lamp_word want;
    } t_tick_row;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [tlms_pkg::IDX_BITS-1:0]        i_cfg_idx;
    logic [tlms_pkg::CFG_BITS-1:0]        i_cfg_data;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic signed [tlms_pkg::CMD_BITS-1:0] i_roll_command;
    logic signed [tlms_pkg::CMD_BITS-1:0] i_pitch_command;
    logic signed [tlms_pkg::CMD_BITS-1:0] i_yaw_command;
    logic [9:0]                           i_dynamic_pressure;
    logic [9:0]                           i_elapsed_ms;
    logic [tlms_pkg::CH_BITS-1:0]         i_first_channel_in;
    logic [tlms_pkg::CH_BITS-1:0]         i_second_channel_in;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic [tlms_pkg::NUM_LAMPS-1:0]       o_lamp_bits;
    logic [tlms_pkg::CH_BITS-1:0]         o_first_channel_out;
    logic [tlms_pkg::CH_BITS-1:0]         o_second_channel_out;
    logic                                 o_high_pressure_mode;

    thruster_lamp_min_on_stretcher_core u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_roll_command       (i_roll_command),
        .i_pitch_command      (i_pitch_command),
        .i_yaw_command        (i_yaw_command),
        .i_dynamic_pressure   (i_dynamic_pressure),
        .i_elapsed_ms         (i_elapsed_ms),
        .i_first_channel_in   (i_first_channel_in),
        .i_second_channel_in  (i_second_channel_in),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_lamp_bits          (o_lamp_bits),
        .o_first_channel_out  (o_first_channel_out),
        .o_second_channel_out (o_second_channel_out),
        .o_high_pressure_mode (o_high_pressure_mode)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Lamp state mirror and its configuration
    tlms_pkg::t_cfg                 model_min_on;
    tlms_pkg::t_cfg                 model_thr;
    tlms_pkg::t_timer               model_timer [tlms_pkg::NUM_LAMPS];
    logic [tlms_pkg::NUM_LAMPS-1:0] model_flags;

    // Pending lamp words, oldest first
    t_lamp_word lamp_words_due [$];
    t_tick_row  directed_rows [$];

    // Override for the transaction currently offered
    logic       cur_typed;
    t_lamp_word cur_want;

    // Random command state, held across ticks
    logic signed [tlms_pkg::CMD_BITS-1:0] hold_roll;
    logic signed [tlms_pkg::CMD_BITS-1:0] hold_pitch;
    logic signed [tlms_pkg::CMD_BITS-1:0] hold_yaw;
    bit                                   sticky_hi;

    bit quiet_mode;
    bit hold_req;

    int error_count;
    int words_checked;
    int ticks_sent;
    int hp_ticks;
    int lit_ticks;
    int settings_used;

    function automatic void model_reset();
        model_min_on = tlms_pkg::MIN_ON_RESET;
        model_thr    = tlms_pkg::PRESS_THR_RESET;
        for (int i = 0; i < tlms_pkg::NUM_LAMPS; i++) begin
            model_timer[i] = '0;
        end
        model_flags = '0;
    endfunction

    function automatic void model_write(input logic [tlms_pkg::IDX_BITS-1:0] idx,
                                        input tlms_pkg::t_cfg data);
        case (idx)
            tlms_pkg::CFG_MIN_ON:    model_min_on = data;
            tlms_pkg::CFG_PRESS_THR: model_thr = data;
            default: ;
        endcase
    endfunction

    // Hold one lamp on for its minimum time; return its new state and timer
    function automatic tlms_pkg::t_stretch stretch_lamp(input logic cmd, input logic was_on,
                                                        input tlms_pkg::t_timer cur,
                                                        input tlms_pkg::t_timer dt);
        tlms_pkg::t_stretch s;
        tlms_pkg::t_timer   count;
        tlms_pkg::t_timer   load;
        count = (cur > dt) ? cur - dt : '0;
        load  = (tlms_pkg::t_cmp'(model_min_on) > tlms_pkg::TIME_MAX_EXT)
              ? tlms_pkg::t_timer'(tlms_pkg::TIME_MAX_EXT)
              : tlms_pkg::t_timer'(model_min_on);
        s.on = 1'b1;
        if (cmd) begin
            s.timer = was_on ? count : load;
        end else if (cur != '0) begin
            s.timer = count;
        end else begin
            s.on    = 1'b0;
            s.timer = cur;
        end
        return s;
    endfunction

    // Advance the mirror by one tick and return the lamp word it produces
    function automatic t_lamp_word predict_lamps(input t_tick tk);
        logic                           hi;
        logic                           yaw_big;
        logic [tlms_pkg::NUM_LAMPS-1:0] cmd;
        logic [tlms_pkg::NUM_LAMPS-1:0] act;
        logic [tlms_pkg::NUM_LAMPS-1:0] on;
        tlms_pkg::t_word                masks;
        tlms_pkg::t_stretch             s;
        t_lamp_word                     res;
        hi      = (tlms_pkg::t_cfg'(tk.press) >= model_thr);
        yaw_big = (tk.yaw >= 3) || (tk.yaw <= -3);
        cmd = '0;
        cmd[tlms_pkg::LAMP_RR] = hi ? yaw_big : (tk.roll > 0);
        cmd[tlms_pkg::LAMP_RL] = tk.roll < 0;
        cmd[tlms_pkg::LAMP_PU] = tk.pitch > 0;
        cmd[tlms_pkg::LAMP_PD] = tk.pitch < 0;
        cmd[tlms_pkg::LAMP_YR] = tk.yaw >= 2;
        cmd[tlms_pkg::LAMP_YL] = tk.yaw <= -2;
        // freeze roll-left and pitch timers in high-pressure mode
        act = '1;
        if (hi) begin
            act[tlms_pkg::LAMP_RL] = 1'b0;
            act[tlms_pkg::LAMP_PU] = 1'b0;
            act[tlms_pkg::LAMP_PD] = 1'b0;
        end
        on = model_flags;
        for (int i = 0; i < tlms_pkg::NUM_LAMPS; i++) begin
            if (act[i]) begin
                s = stretch_lamp(cmd[i], model_flags[i], model_timer[i], tk.dt);
                on[i] = s.on;
                model_timer[i] = s.timer;
            end
        end
        if (hi) begin
            on[tlms_pkg::LAMP_RL] = on[tlms_pkg::LAMP_RR];
            on[tlms_pkg::LAMP_PU] = 1'b0;
            on[tlms_pkg::LAMP_PD] = 1'b0;
        end
        masks = '0;
        for (int i = 0; i < tlms_pkg::NUM_LAMPS; i++) begin
            if (on[i]) masks = masks | tlms_pkg::LAMP_MASK[i];
        end
        model_flags = on;
        res.lamps = on;
        res.ch1   = tk.ch1 | masks;
        res.ch2   = tk.ch2 | masks;
        res.hp    = hi;
        return res;
    endfunction

    function automatic t_tick mk_tick(input int r, input int p, input int y, input int q,
                                      input int dt, input int c1, input int c2);
        t_tick tk;
        tk.roll  = r[7:0];
        tk.pitch = p[7:0];
        tk.yaw   = y[7:0];
        tk.press = q[9:0];
        tk.dt    = dt[9:0];
        tk.ch1   = c1[15:0];
        tk.ch2   = c2[15:0];
        return tk;
    endfunction

    function automatic void add_row(input t_tick tk, input logic typed, input t_lamp_word want);
        t_tick_row row;
        row.tk    = tk;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [tlms_pkg::CMD_BITS-1:0] pick_cmd();
        int                                   r;
        logic signed [tlms_pkg::CMD_BITS-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 30)      v = '0;
        else if (r < 65) v = tlms_pkg::CMD_BITS'(int'($urandom_range(0, 8)) - 4);
        else if (r < 80) v = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
        else             v = tlms_pkg::CMD_BITS'($urandom);
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_mode || hold_req) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build a tick: commands held over runs, pressure mostly near the threshold
    task automatic make_tick(output t_tick tk);
        int r;
        int q;
        if ($urandom_range(0, 3) == 0) hold_roll = pick_cmd();
        if ($urandom_range(0, 3) == 0) hold_pitch = pick_cmd();
        if ($urandom_range(0, 3) == 0) hold_yaw = pick_cmd();
        if ($urandom_range(0, 9) == 0) sticky_hi = !sticky_hi;
        r = $urandom_range(0, 99);
        if (r < 20)          q = $urandom_range(0, 1023);
        else if (sticky_hi)  q = int'(model_thr) + int'($urandom_range(0, 2));
        else                 q = int'(model_thr) - 1 - int'($urandom_range(0, 2));
        if (q < 0) q = 0;
        if (q > 1023) q = 1023;
        tk.roll  = hold_roll;
        tk.pitch = hold_pitch;
        tk.yaw   = hold_yaw;
        tk.press = q[9:0];
        r = $urandom_range(0, 99);
        if (r < 45)      tk.dt = 10'($urandom_range(0, 15));
        else if (r < 70) tk.dt = 10'($urandom_range(0, int'(model_min_on)));
        else if (r < 80) tk.dt = '0;
        else if (r < 92) tk.dt = 10'($urandom_range(0, 1023));
        else             tk.dt = 10'd1023;
        tk.ch1 = tlms_pkg::t_word'($urandom);
        tk.ch2 = tlms_pkg::t_word'($urandom);
    endtask

    // Offer one tick and hold it until the transaction completes
    task automatic send_tick(input t_tick tk, input logic typed, input t_lamp_word want);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_roll_command      = tk.roll;
        i_pitch_command     = tk.pitch;
        i_yaw_command       = tk.yaw;
        i_dynamic_pressure  = tk.press;
        i_elapsed_ms        = tk.dt;
        i_first_channel_in  = tk.ch1;
        i_second_channel_in = tk.ch2;
        cur_typed           = typed;
        cur_want            = want;
        i_in_valid          = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    // Drop valid and wait until every lamp word has come back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (lamp_words_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tlms_pkg::IDX_BITS-1:0] idx,
                             input tlms_pkg::t_cfg data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        model_write(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Predict on input transactions, check output transactions
    always @(posedge i_clk) begin : lamp_check
        t_tick      seen;
        t_lamp_word want;
        t_lamp_word pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (o_high_pressure_mode) hp_ticks++;
                if (o_lamp_bits != '0) lit_ticks++;
                if (lamp_words_due.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected lamp word: lamps %02h ch1 %04h ch2 %04h mode %0d",
                                 o_lamp_bits, o_first_channel_out, o_second_channel_out,
                                 o_high_pressure_mode);
                end else begin
                    want = lamp_words_due.pop_front();
                    words_checked++;
                    if (o_lamp_bits !== want.lamps || o_first_channel_out !== want.ch1 ||
                        o_second_channel_out !== want.ch2 ||
                        o_high_pressure_mode !== want.hp) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display({"mismatch at word %0d: lamps exp %02h got %02h, ",
                                      "%s%04h %s%04h, %s%04h %s%04h, %s%0d %s%0d"},
                                     words_checked, want.lamps, o_lamp_bits,
                                     "ch1 exp ", want.ch1, "got ", o_first_channel_out,
                                     "ch2 exp ", want.ch2, "got ", o_second_channel_out,
                                     "mode exp ", want.hp, "got ", o_high_pressure_mode);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                seen.roll  = i_roll_command;
                seen.pitch = i_pitch_command;
                seen.yaw   = i_yaw_command;
                seen.press = i_dynamic_pressure;
                seen.dt    = i_elapsed_ms;
                seen.ch1   = i_first_channel_in;
                seen.ch2   = i_second_channel_in;
                pred = predict_lamps(seen);
                lamp_words_due.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    // Receiver: random stalls, one long hold-off while the sender streams
    initial begin : lamp_sink
        int r;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held        = 1'b1;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (quiet_mode) begin
                i_out_ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_out_ready = 1'b1;
                end else if (r < 94) begin
                    i_out_ready = 1'b0;
                end else begin
                    i_out_ready = 1'b0;
                    repeat ($urandom_range(8, 40)) @(negedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_tick          tk;
        tlms_pkg::t_cfg min_v;
        tlms_pkg::t_cfg thr_v;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = tlms_pkg::CFG_MIN_ON;
        i_cfg_data          = '0;
        i_in_valid          = 1'b0;
        i_roll_command      = '0;
        i_pitch_command     = '0;
        i_yaw_command       = '0;
        i_dynamic_pressure  = '0;
        i_elapsed_ms        = '0;
        i_first_channel_in  = '0;
        i_second_channel_in = '0;
        i_out_ready         = 1'b0;
        cur_typed           = 1'b0;
        cur_want            = '0;
        hold_roll           = '0;
        hold_pitch          = '0;
        hold_yaw            = '0;
        sticky_hi           = 1'b0;
        quiet_mode          = 1'b0;
        hold_req            = 1'b0;
        error_count         = 0;
        words_checked       = 0;
        ticks_sent          = 0;
        hp_ticks            = 0;
        lit_ticks           = 0;
        settings_used       = 1;
        model_reset();

        // Directed ticks at reset settings (min on 200, threshold 50)
        // all lamps dark right after reset
        add_row(mk_tick(0, 0, 0, 0, 0, 'h0000, 'h0000), 1'b1, '0);
        // full positive commands turn on right, up and yaw right
        add_row(mk_tick(127, 127, 127, 0, 0, 'hFFFF, 'h0000), 1'b1,
                {6'h15, 16'hFFFF, 16'h0D00, 1'b0});
        // full negative: new lamps load, old ones count down but stay lit
        add_row(mk_tick(-128, -128, -128, 0, 1023, 'h0000, 'hFFFF), 1'b1,
                {6'h3F, 16'h1F80, 16'hFFFF, 1'b0});
        // release: timers run out with the elapsed time
        add_row(mk_tick(0, 0, 0, 0, 5, 'h1234, 'h8001), 1'b0, '0);
        add_row(mk_tick(0, 0, 0, 0, 1023, 'hA5A5, 'h5A5A), 1'b0, '0);
        add_row(mk_tick(0, 0, 0, 0, 0, 'h0000, 'h0000), 1'b0, '0);
        // smallest commands held, just below the threshold
        add_row(mk_tick(1, -1, 2, 49, 10, 'h0001, 'h8000), 1'b0, '0);
        add_row(mk_tick(1, -1, 2, 49, 100, 'h0002, 'h4000), 1'b0, '0);
        add_row(mk_tick(1, -1, 2, 49, 100, 'h0004, 'h2000), 1'b0, '0);
        add_row(mk_tick(0, 0, 1, 49, 50, 'h0008, 'h1000), 1'b0, '0);
        add_row(mk_tick(0, 0, 0, 0, 50, 'h0010, 'h0800), 1'b0, '0);
        add_row(mk_tick(0, 0, 0, 0, 50, 'h0020, 'h0400), 1'b0, '0);
        // high pressure: pressure at and above the threshold, yaw at 3, -3, -2, 2
        add_row(mk_tick(5, 5, 3, 50, 10, 'h0040, 'h0200), 1'b0, '0);
        add_row(mk_tick(-5, -5, -3, 1023, 10, 'h0080, 'h0100), 1'b0, '0);
        add_row(mk_tick(0, 0, -2, 1023, 10, 'h0100, 'h0080), 1'b0, '0);
        add_row(mk_tick(0, -7, 2, 500, 10, 'h0200, 'h0040), 1'b0, '0);
        // pitch timer frozen through high pressure, then holds lamp again
        add_row(mk_tick(0, 100, 0, 0, 0, 'h0400, 'h0020), 1'b0, '0);
        add_row(mk_tick(0, 100, 0, 1023, 1023, 'h0800, 'h0010), 1'b0, '0);
        add_row(mk_tick(0, 0, 0, 0, 10, 'h1000, 'h0008), 1'b0, '0);
        add_row(mk_tick(-1, 0, -1, 49, 0, 'h2000, 'h0004), 1'b0, '0);
        add_row(mk_tick(127, -128, 127, 1023, 0, 'hFFFF, 'hFFFF), 1'b0, '0);
        add_row(mk_tick(0, 0, -128, 1023, 1, 'h4000, 'h0002), 1'b0, '0);
        add_row(mk_tick(0, 0, 0, 0, 1023, 'h8000, 'h0001), 1'b0, '0);

        // Hold reset, then release on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            send_tick(directed_rows[k].tk, directed_rows[k].typed, directed_rows[k].want);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       begin min_v = 10'd0;    thr_v = 10'd0;    end
                1:       begin min_v = 10'd1023; thr_v = 10'd1023; end
                2:       begin min_v = 10'd1;    thr_v = 10'd512;  end
                3:       begin min_v = 10'd1023; thr_v = 10'd0;    end
                4:       begin min_v = 10'd50;   thr_v = 10'd300;  end
                5:       begin min_v = 10'd0;    thr_v = 10'd1023; end
                default: begin
                    min_v = tlms_pkg::t_cfg'($urandom_range(0, 1023));
                    thr_v = tlms_pkg::t_cfg'($urandom_range(0, 1023));
                end
            endcase
            write_reg(tlms_pkg::CFG_MIN_ON, min_v);
            write_reg(tlms_pkg::CFG_PRESS_THR, thr_v);
            // undecoded index must leave both registers alone
            write_reg(ph[0] ? CFG_SPARE_HI : CFG_SPARE_LO, tlms_pkg::t_cfg'($urandom));
            settings_used++;
            quiet_mode = (ph == 2);
            hold_req   = (ph == 4);
            repeat (PHASE_TICKS) begin
                make_tick(tk);
                send_tick(tk, 1'b0, '0);
            end
        end
        quiet_mode = 1'b0;
        hold_req   = 1'b0;
        settle();

        $display("sent %0d ticks (%0d directed) over %0d register settings",
                 ticks_sent, directed_rows.size(), settings_used);
        $display("checked %0d lamp words: %0d with lamps lit, %0d in high-pressure mode",
                 words_checked, lit_ticks, hp_ticks);
        if (error_count == 0 && lamp_words_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
